[sv/mie_pkg.sv]
package mie_pkg;

    // Default operand width and modulus after reset
    localparam int          DEF_WIDTH     = 32;
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // take the operand word, start reducing it by the modulus
        logic div_init;   // start dividing r0 by r1
        logic div_step;   // one restoring division step
        logic red_done;   // keep the reduced operand as r1
        logic upd;        // advance one Euclid step
        logic fin_write;  // write the result word to the output register
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mod_zero;   // modulus is zero
        logic r1_zero;    // current remainder is zero
        logic out_free;   // output register can take a word this cycle
    } ctl_sts_t;

endpackage

[sv/mie_datapath.sv]
module mie_datapath #(
    parameter int WIDTH = mie_pkg::DEF_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [WIDTH-1:0]     operand,
    input  logic [WIDTH-1:0]     modulus,
    input  logic                 out_ready,
    input  mie_pkg::ctl_cmd_t    cmd,
    output mie_pkg::ctl_sts_t    sts,
    output logic [WIDTH-1:0]     inverse,
    output logic                 exists,
    output logic                 out_valid
);

    // Euclid state: remainders and coefficient magnitudes with signs
    logic [WIDTH-1:0] r0_reg, r0_next;
    logic [WIDTH-1:0] r1_reg, r1_next;
    logic [WIDTH-1:0] mag0_reg, mag0_next;
    logic [WIDTH-1:0] mag1_reg, mag1_next;
    logic             neg0_reg, neg0_next;
    logic             neg1_reg, neg1_next;

    // Shared divider: dividend shifter, divisor, partial remainder, product accumulator
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] acc_reg, acc_next;

    // Output register
    logic [WIDTH-1:0] inv_reg, inv_next;
    logic             ok_reg, ok_next;
    logic             vld_reg, vld_next;

    logic [WIDTH+1:0] diff;
    logic             qbit;
    logic [WIDTH-1:0] rem_step;
    logic [WIDTH-1:0] acc_step;
    logic [WIDTH-1:0] mag_red;
    logic [WIDTH-1:0] inv_fin;
    logic             ok_fin;

    // Trial subtract for one quotient bit, MSB first
    assign diff     = {1'b0, rem_reg, dvd_reg[WIDTH-1]} - {2'b00, dsr_reg};
    assign qbit     = ~diff[WIDTH+1];
    assign rem_step = qbit ? diff[WIDTH-1:0] : {rem_reg[WIDTH-2:0], dvd_reg[WIDTH-1]};
    // Build q * mag1 bit by bit alongside the quotient
    assign acc_step = {acc_reg[WIDTH-2:0], 1'b0} + (qbit ? mag1_reg : '0);

    // Normalise the final coefficient into 0..modulus-1
    assign mag_red = (mag0_reg == modulus) ? '0 : mag0_reg;
    assign ok_fin  = (r0_reg == WIDTH'(1));
    assign inv_fin = !ok_fin ? '0 :
                     (neg0_reg && (mag_red != '0)) ? (modulus - mag_red) : mag_red;

    // Next-state selection from the command word
    always_comb
    begin
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        mag0_next = mag0_reg;
        mag1_next = mag1_reg;
        neg0_next = neg0_reg;
        neg1_next = neg1_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        inv_next  = inv_reg;
        ok_next   = ok_reg;
        if (cmd.load)
        begin
            r0_next   = modulus;
            mag0_next = '0;
            mag1_next = WIDTH'(1);
            neg0_next = 1'b0;
            neg1_next = 1'b0;
            dvd_next  = operand;
            dsr_next  = modulus;
            rem_next  = '0;
            acc_next  = '0;
        end
        if (cmd.div_init)
        begin
            dvd_next = r0_reg;
            dsr_next = r1_reg;
            rem_next = '0;
            acc_next = '0;
        end
        if (cmd.div_step)
        begin
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            rem_next = rem_step;
            acc_next = acc_step;
        end
        if (cmd.red_done)
        begin
            r1_next = rem_reg;
        end
        if (cmd.upd)
        begin
            r0_next   = r1_reg;
            r1_next   = rem_reg;
            mag0_next = mag1_reg;
            neg0_next = neg1_reg;
            mag1_next = acc_reg + mag0_reg;
            neg1_next = ~neg1_reg;
        end
        if (cmd.fin_write)
        begin
            inv_next = inv_fin;
            ok_next  = ok_fin;
        end
    end

    // Hold the output word until taken
    assign vld_next = cmd.fin_write ? 1'b1 : (out_ready ? 1'b0 : vld_reg);

    always_ff @(posedge clk)
    begin
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        mag0_reg <= mag0_next;
        mag1_reg <= mag1_next;
        neg0_reg <= neg0_next;
        neg1_reg <= neg1_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        inv_reg  <= inv_next;
        ok_reg   <= ok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign sts.mod_zero = (modulus == '0);
    assign sts.r1_zero  = (r1_reg == '0);
    assign sts.out_free = ~vld_reg | out_ready;

    assign inverse   = inv_reg;
    assign exists    = ok_reg;
    assign out_valid = vld_reg;

endmodule

[sv/mie_ctrl.sv]
module mie_ctrl #(
    parameter int WIDTH = mie_pkg::DEF_WIDTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mie_pkg::ctl_sts_t sts,
    output mie_pkg::ctl_cmd_t cmd
);

    localparam int CW = $clog2(WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_RFIN,
        ST_CHK,
        ST_DIV,
        ST_UPD,
        ST_FIN
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          last;

    assign last = (cnt_reg == CW'(WIDTH - 1));

    // Sequence reduction, then division and update per Euclid step
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = sts.mod_zero ? ST_FIN : ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (last)
                begin
                    state_next = ST_RFIN;
                end
            end
            ST_RFIN:
            begin
                cmd.red_done = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.r1_zero)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CW'(1);
                if (last)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_CHK;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.fin_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[sv/modular_inverse_ext_euclid.sv]
// Channel  Dir  Payload                                    Handshake
// s_*      in   tdata: operand                             tvalid/tready
// m_*      out  tdata: inverse; tuser: exists              tvalid/tready
// cfg_*    in   cfg_data: modulus                          cfg_valid/cfg_ready
//
// One word at a time. A word is first reduced by the modulus, then takes one division and one
// update per Euclid step (up to about 46 steps at WIDTH 32) until the remainder is zero;
// the shared restoring divider yields one quotient bit per cycle.
// Reset (rst_n, asynchronous) sets the modulus to 1000000007 and empties the block.
// A stalled result sits in the output register; the next operand word is taken once
// that result has been written there.
module modular_inverse_ext_euclid #(
    parameter int WIDTH = mie_pkg::DEF_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((WIDTH + 7) / 8) * 8-1:0]  s_tdata,   // [WIDTH-1:0] operand
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((WIDTH + 7) / 8) * 8-1:0]  m_tdata,   // [WIDTH-1:0] inverse
    output logic                              m_tuser,   // [0] exists
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [WIDTH-1:0]                  cfg_data
);

    localparam int TDW = ((WIDTH + 7) / 8) * 8;

    logic [WIDTH-1:0]  mod_reg, mod_next;
    mie_pkg::ctl_cmd_t cmd;
    mie_pkg::ctl_sts_t sts;
    logic [WIDTH-1:0]  inverse;
    logic              exists;

    // Modulus register, always writable
    assign cfg_ready = 1'b1;
    assign mod_next  = (cfg_valid && cfg_ready) ? cfg_data : mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= WIDTH'(mie_pkg::MODULUS_RESET);
        end
        else
        begin
            mod_reg <= mod_next;
        end
    end

    mie_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mie_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .operand   (s_tdata[WIDTH-1:0]),
        .modulus   (mod_reg),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .inverse   (inverse),
        .exists    (exists),
        .out_valid (m_tvalid)
    );

    assign m_tdata = TDW'(inverse);
    assign m_tuser = exists;

    // A valid inverse lies below the modulus
    a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && exists) |-> (inverse < mod_reg))
        else $error("inverse not below modulus");

    // No inverse reads as zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !exists) |-> (inverse == '0))
        else $error("nonzero inverse without exists");

    // One word in flight: the block is busy right after taking an operand
    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("operand taken while busy");

endmodule
